### rtl/core/trimmed_mean_adc_to_millivolts_defines.svh
// Assertion macros shared by the trimmed-mean ADC filter RTL.
`ifndef TRIMMED_MEAN_ADC_TO_MILLIVOLTS_DEFINES_SVH
`define TRIMMED_MEAN_ADC_TO_MILLIVOLTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMADC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMADC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tmadc_pkg.sv
// Types and constants of the trimmed-mean ADC filter.
package tmadc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int WINDOW_LEN  = 9;
  localparam int SKIP_COUNT  = 3;
  localparam int POS_BITS    = 4;
  localparam int SUM_BITS    = SAMPLE_BITS + 3;
  localparam int MV_BITS     = 16;
  localparam int PROD_BITS   = SAMPLE_BITS + MV_BITS;
  localparam int EST_BITS    = PROD_BITS + 1;
  localparam int QUOT_BITS   = EST_BITS - SAMPLE_BITS;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;

  typedef logic [SAMPLE_BITS-1:0] code_t;
  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [MV_BITS-1:0]     mv_t;
  typedef logic [PROD_BITS-1:0]   prod_t;
  typedef logic [EST_BITS-1:0]    est_t;
  typedef logic [QUOT_BITS-1:0]   quot_t;

  localparam code_t CODE_MAX         = '1;
  localparam pos_t  LAST_POS         = pos_t'(WINDOW_LEN - 1);
  localparam pos_t  SKIP_POS         = pos_t'(SKIP_COUNT);
  localparam mv_t   FULL_SCALE_RESET = mv_t'(4800);

  typedef enum logic [ADDR_BITS-3:0] {
    REG_FULL_SCALE = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic  valid;
    code_t avg;
  } avg_stage_t;

endpackage

### rtl/core/tmadc_window.sv
// Window accumulator: tracks max, min and sum of the kept samples and forms the average.
module tmadc_window (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  tmadc_pkg::code_t       sample_code_i,
  input  logic                   ready_i,
  output logic                   in_stall_o,
  output tmadc_pkg::avg_stage_t  stage_o,
  output tmadc_pkg::pos_t        pos_o
);
  import tmadc_pkg::*;

  pos_t  pos_q, pos_d;
  code_t max_q, max_d;
  code_t min_q, min_d;
  sum_t  sum_q, sum_d;
  logic  valid_q, valid_d;
  code_t avg_q;

  logic  rdy;
  logic  acc;
  logic  kept;
  logic  last;
  code_t max_n;
  code_t min_n;
  sum_t  sum_n;
  sum_t  rem;

  assign rdy        = !valid_q || ready_i;
  assign acc        = in_valid_i && rdy;
  assign in_stall_o = !rdy;

  always_comb begin
    kept  = (pos_q >= SKIP_POS) && (pos_q <= LAST_POS);
    last  = (pos_q == LAST_POS);
    max_n = (kept && (sample_code_i > max_q)) ? sample_code_i : max_q;
    min_n = (kept && (sample_code_i < min_q)) ? sample_code_i : min_q;
    sum_n = kept ? (sum_q + sum_t'(sample_code_i)) : sum_q;
    rem   = sum_n - sum_t'(max_n) - sum_t'(min_n);

    pos_d   = pos_q;
    max_d   = max_q;
    min_d   = min_q;
    sum_d   = sum_q;
    valid_d = valid_q;
    if (rdy) begin
      valid_d = acc && last;
    end
    if (acc) begin
      if (last || (pos_q > LAST_POS)) begin
        pos_d = '0;
        max_d = '0;
        min_d = CODE_MAX;
        sum_d = '0;
      end else begin
        pos_d = pos_q + pos_t'(1);
        max_d = max_n;
        min_d = min_n;
        sum_d = sum_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      max_q   <= '0;
      min_q   <= CODE_MAX;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      max_q   <= max_d;
      min_q   <= min_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && last) begin
      avg_q <= code_t'(rem[SUM_BITS-1:2]);
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.avg   = avg_q;
  assign pos_o         = pos_q;

endmodule

### rtl/core/tmadc_scale.sv
// Millivolt scaling pipeline: multiply by full scale, divide by the full-scale code.
module tmadc_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tmadc_pkg::avg_stage_t  stage_i,
  input  tmadc_pkg::mv_t         full_scale_mv_i,
  input  logic                   out_stall_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  output tmadc_pkg::code_t       average_code_o,
  output tmadc_pkg::mv_t         millivolts_o
);
  import tmadc_pkg::*;

  logic  v2_q, v3_q, vo_q;
  code_t avg2_q, avg3_q, avgo_q;
  prod_t prod_q, x3_q;
  quot_t q0_q;
  mv_t   mv_q;

  logic  rdy_o, rdy3, rdy2;
  est_t  est;
  est_t  back;
  est_t  rem;
  quot_t quot;

  assign rdy_o   = !vo_q || !out_stall_i;
  assign rdy3    = !v3_q || rdy_o;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  always_comb begin
    est = est_t'(prod_q) + est_t'(prod_q >> SAMPLE_BITS)
        + est_t'(prod_q >> (2 * SAMPLE_BITS)) + est_t'(prod_q >> (3 * SAMPLE_BITS));
    back = (est_t'(q0_q) << SAMPLE_BITS) - est_t'(q0_q);
    rem  = est_t'(x3_q) - back;
    quot = (rem >= est_t'(CODE_MAX)) ? (q0_q + quot_t'(1)) : q0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= stage_i.valid;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_o) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && stage_i.valid) begin
      avg2_q <= stage_i.avg;
      prod_q <= prod_t'(stage_i.avg) * prod_t'(full_scale_mv_i);
    end
    if (rdy3 && v2_q) begin
      avg3_q <= avg2_q;
      x3_q   <= prod_q;
      q0_q   <= est[EST_BITS-1:SAMPLE_BITS];
    end
    if (rdy_o && v3_q) begin
      avgo_q <= avg3_q;
      mv_q   <= mv_t'(quot);
    end
  end

  assign out_valid_o    = vo_q;
  assign average_code_o = avgo_q;
  assign millivolts_o   = mv_q;

endmodule

### rtl/core/trimmed_mean_adc_to_millivolts.sv
// Trimmed-mean ADC filter top level with register port and checks.
// One sample is accepted per cycle while in_stall_o is low; every ninth sample closes a
// window and yields one item. The item passes through the accumulate stage, the multiplier
// stage and two division stages, any of which out_stall_i can hold.
// Reset clears the window state and the stage valids, and sets full_scale_mv to 4800.
`include "trimmed_mean_adc_to_millivolts_defines.svh"

module trimmed_mean_adc_to_millivolts (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  tmadc_pkg::code_t                      sample_code_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tmadc_pkg::code_t                      average_code_o,
  output tmadc_pkg::mv_t                        millivolts_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tmadc_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [tmadc_pkg::DATA_BITS-1:0]       pwdata,
  output logic [tmadc_pkg::DATA_BITS-1:0]       prdata,
  output logic                                  pready
);
  import tmadc_pkg::*;

  mv_t        fs_q, fs_d;
  reg_idx_e   reg_idx;
  logic       wr_en;
  avg_stage_t stage;
  pos_t       pos;
  logic       scale_ready;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    fs_d = fs_q;
    if (wr_en) begin
      case (reg_idx)
        REG_FULL_SCALE: fs_d = mv_t'(pwdata);
        default:        fs_d = fs_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FULL_SCALE: prdata = DATA_BITS'(fs_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FULL_SCALE_RESET;
    end else begin
      fs_q <= fs_d;
    end
  end

  tmadc_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .sample_code_i (sample_code_i),
    .ready_i       (scale_ready),
    .in_stall_o    (in_stall_o),
    .stage_o       (stage),
    .pos_o         (pos)
  );

  tmadc_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .full_scale_mv_i (fs_q),
    .out_stall_i     (out_stall_i),
    .ready_o         (scale_ready),
    .out_valid_o     (out_valid_o),
    .average_code_o  (average_code_o),
    .millivolts_o    (millivolts_o)
  );

  `TMADC_ASSERT_IMPL(a_pos_range, 1'b1, pos <= LAST_POS, "window position out of range")
  `TMADC_ASSERT_IMPL(a_stall_full, in_stall_o, out_valid_o && stage.valid, "stall without full pipe")
  `TMADC_ASSERT_IMPL(a_mv_bound, out_valid_o, millivolts_o <= fs_q, "millivolts above full scale")
  `TMADC_ASSERT_NEXT(a_close_window, in_valid_i && !in_stall_o && pos == LAST_POS, stage.valid,
                     "closed window produced no average")

endmodule
